>>> rtl/rtf_pkg.sv
// Shared types and constants for the radix token maximum finder.
// Holds the status codes, character codes and the result record.
// Depends on nothing.
package rtf_pkg;

  localparam int CHAR_W  = 8;
  localparam int RADIX_W = 6;
  localparam int VAL_W   = 63;
  localparam int DIGIT_W = 6;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [VAL_W-1:0]   VAL_MAX     = {VAL_W{1'b1}};

  // Character codes the parser decodes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h74;
  localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_P     = 8'h70;

  // Stop-word window positions
  typedef enum logic [1:0] {
    STOP_IDLE   = 2'd0,
    STOP_WANT_O = 2'd1,
    STOP_WANT_P = 2'd2
  } stop_pos_t;

  typedef enum logic [1:0] {
    ST_RUN       = 2'd0,
    ST_STOP      = 2'd1,
    ST_SIGN_ERR  = 2'd2,
    ST_INPUT_ERR = 2'd3
  } status_t;

  // One result transaction, last field in the lowest bits
  typedef struct packed {
    logic             saturated;
    logic             have_number;
    logic [VAL_W-1:0] max_value;
    status_t          status;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_W    = ((RESULT_W + 7) / 8) * 8;

endpackage

>>> rtl/radix_token_max_finder.sv
// Top level of the radix token maximum finder: parser state, result
// register and skid stage. Depends on rtf_pkg.
//
// Results go to the output register, or to the skid stage while it is held.
// Throughput: one character per cycle while the skid is empty; the token update
// is one 63x6 multiply, an add and an overflow test in the cycle the character
// is accepted. Result register plus skid keep in_tready high while one result
// waits. Reset (sync, active low) clears parser state and valid flags, radix = 10.
module radix_token_max_finder (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel: radix
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtf_pkg::RADIX_W-1:0]       cfg_data,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rtf_pkg::CHAR_W-1:0]        in_tdata,   // [7:0] char_in
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] status, [64:2] max_value, [65] have_number, [66] saturated, rest 0
  output logic [rtf_pkg::OUT_W-1:0]         out_tdata
);

  localparam int VW = rtf_pkg::VAL_W;
  localparam int RW = rtf_pkg::RADIX_W;
  localparam int DW = rtf_pkg::DIGIT_W;
  localparam int PW = VW + RW;     // product width
  localparam int SW = PW + 1;      // product plus digit

  // Parser state
  logic [RW-1:0]    radix_r;
  logic [VW-1:0]    acc_r, acc_nxt;
  logic             tok_open_r, tok_open_nxt;
  logic             bad_digit_r, bad_digit_nxt;
  logic             sign_pend_r, sign_pend_nxt;
  logic             prev_s_r, prev_s_nxt;
  rtf_pkg::stop_pos_t stop_pos_r, stop_pos_nxt;
  logic             stop_miss_r, stop_miss_nxt;
  logic [VW-1:0]    max_r, max_nxt;
  logic             seen_r, seen_nxt;
  logic             ovf_r, ovf_nxt;
  rtf_pkg::status_t status_r, status_nxt;

  // Output stages
  logic             out_v_r, out_v_nxt;
  logic             skid_v_r, skid_v_nxt;
  rtf_pkg::result_t out_data_r, out_data_nxt;
  rtf_pkg::result_t skid_data_r, skid_data_nxt;

  // Character decode and token arithmetic
  logic             in_acc, out_take;
  logic [rtf_pkg::CHAR_W-1:0] ch;
  logic             is_sep, is_num, is_alpha, is_tok;
  logic [DW-1:0]    digit;
  logic [PW-1:0]    prod;
  logic [SW-1:0]    sum;
  logic             sum_ovf;
  rtf_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_v_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_take  = out_v_r && out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata = rtf_pkg::OUT_W'(out_data_r);

  // Decode the character
  assign ch       = in_tdata;
  assign is_sep   = (ch == rtf_pkg::CH_SPACE) || (ch == rtf_pkg::CH_LF) ||
                    (ch == rtf_pkg::CH_TAB);
  assign is_num   = (ch >= rtf_pkg::CH_0) && (ch <= rtf_pkg::CH_9);
  assign is_alpha = (ch >= rtf_pkg::CH_A) && (ch <= rtf_pkg::CH_Z);
  assign is_tok   = is_num || is_alpha;

  always_comb begin
    digit = '0;
    if (is_num) begin
      digit = DW'(ch - rtf_pkg::CH_0);
    end else if (is_alpha) begin
      digit = DW'(ch - rtf_pkg::CH_A) + DW'(10);
    end
  end

  // Multiply-add with overflow test against 2^63-1
  assign prod    = PW'(acc_r) * PW'(radix_r);
  assign sum     = SW'(prod) + SW'(digit);
  assign sum_ovf = |sum[SW-1:VW];

  // Next parser state for the offered character
  always_comb begin
    acc_nxt       = acc_r;
    tok_open_nxt  = tok_open_r;
    bad_digit_nxt = bad_digit_r;
    sign_pend_nxt = sign_pend_r;
    prev_s_nxt    = prev_s_r;
    stop_pos_nxt  = stop_pos_r;
    stop_miss_nxt = stop_miss_r;
    max_nxt       = max_r;
    seen_nxt      = seen_r;
    ovf_nxt       = ovf_r;
    status_nxt    = status_r;

    if (status_r != rtf_pkg::ST_RUN) begin
      // sticky: hold everything
    end else if (stop_pos_r != rtf_pkg::STOP_IDLE) begin
      // inside the stop-word window
      if (is_sep) begin
        status_nxt = rtf_pkg::ST_INPUT_ERR;
      end else if (stop_pos_r == rtf_pkg::STOP_WANT_O) begin
        if (ch != rtf_pkg::CH_O) stop_miss_nxt = 1'b1;
        stop_pos_nxt = rtf_pkg::STOP_WANT_P;
      end else begin
        status_nxt = (stop_miss_r || (ch != rtf_pkg::CH_P)) ?
                     rtf_pkg::ST_INPUT_ERR : rtf_pkg::ST_STOP;
        stop_miss_nxt = stop_miss_r || (ch != rtf_pkg::CH_P);
        stop_pos_nxt  = rtf_pkg::STOP_IDLE;
      end
    end else if (sign_pend_r && !is_tok) begin
      status_nxt = rtf_pkg::ST_SIGN_ERR;
    end else begin
      sign_pend_nxt = 1'b0;
      if (is_sep) begin
        // close an open token
        if (tok_open_r) begin
          if (bad_digit_r) begin
            status_nxt = rtf_pkg::ST_INPUT_ERR;
          end else begin
            if (acc_r > max_r) max_nxt = acc_r;
            seen_nxt = 1'b1;
          end
          acc_nxt       = '0;
          bad_digit_nxt = 1'b0;
          tok_open_nxt  = 1'b0;
          prev_s_nxt    = 1'b0;
        end
      end else if (is_tok) begin
        // accumulate one digit, saturating
        if (DW'(radix_r) <= digit) bad_digit_nxt = 1'b1;
        if (sum_ovf) begin
          acc_nxt = rtf_pkg::VAL_MAX;
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = sum[VW-1:0];
        end
        tok_open_nxt = 1'b1;
        prev_s_nxt   = (ch == rtf_pkg::CH_S);
      end else if (ch == rtf_pkg::CH_MINUS) begin
        sign_pend_nxt = 1'b1;
      end else if (prev_s_r) begin
        stop_pos_nxt  = rtf_pkg::STOP_WANT_O;
        stop_miss_nxt = (ch != rtf_pkg::CH_T);
      end else begin
        status_nxt = rtf_pkg::ST_INPUT_ERR;
      end
    end
  end

  assign res.status      = status_nxt;
  assign res.max_value   = max_nxt;
  assign res.have_number = seen_nxt;
  assign res.saturated   = ovf_nxt;

  // Advance parser state and radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= rtf_pkg::RADIX_RESET;
      acc_r       <= '0;
      tok_open_r  <= 1'b0;
      bad_digit_r <= 1'b0;
      sign_pend_r <= 1'b0;
      prev_s_r    <= 1'b0;
      stop_pos_r  <= rtf_pkg::STOP_IDLE;
      stop_miss_r <= 1'b0;
      max_r       <= '0;
      seen_r      <= 1'b0;
      ovf_r       <= 1'b0;
      status_r    <= rtf_pkg::ST_RUN;
    end else begin
      if (cfg_valid && cfg_ready) radix_r <= cfg_data;
      if (in_acc) begin
        acc_r       <= acc_nxt;
        tok_open_r  <= tok_open_nxt;
        bad_digit_r <= bad_digit_nxt;
        sign_pend_r <= sign_pend_nxt;
        prev_s_r    <= prev_s_nxt;
        stop_pos_r  <= stop_pos_nxt;
        stop_miss_r <= stop_miss_nxt;
        max_r       <= max_nxt;
        seen_r      <= seen_nxt;
        ovf_r       <= ovf_nxt;
        status_r    <= status_nxt;
      end
    end
  end

  // Steer results into the output register or the skid stage
  always_comb begin
    out_v_nxt     = out_v_r;
    skid_v_nxt    = skid_v_r;
    out_data_nxt  = out_data_r;
    skid_data_nxt = skid_data_r;
    if (out_take || !out_v_r) begin
      if (skid_v_r) begin
        out_data_nxt = skid_data_r;
        out_v_nxt    = 1'b1;
        skid_v_nxt   = 1'b0;
      end else begin
        out_data_nxt = res;
        out_v_nxt    = in_acc;
      end
    end else if (in_acc) begin
      skid_data_nxt = res;
      skid_v_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid stage holds data while output register is empty");

  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r != rtf_pkg::ST_RUN) |=> (status_r == $past(status_r)))
    else $error("final status changed after being set");

  a_max_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |=> (max_r >= $past(max_r)))
    else $error("running maximum decreased");

endmodule

>>> tb/radix_token_max_finder_checker.sv
// Result checker for radix_token_max_finder: follows radix writes and the
// character stream, predicts every result transaction and compares it.
// Depends on rtf_pkg; instantiated beside the DUT by the test top.
module radix_token_max_finder_checker
  import rtf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [RADIX_W-1:0] cfg_data,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [CHAR_W-1:0]  in_tdata,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [OUT_W-1:0]   out_tdata,
  output int                 mismatch_count,
  output int                 reports_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Parser state as the DUT should hold it
  logic [RADIX_W-1:0] radix_q;
  logic [VAL_W-1:0]   token_value;
  logic               token_open;
  logic               token_bad;
  logic               sign_pending;
  logic               last_was_s;
  stop_pos_t          stop_pos;
  logic               stop_miss;
  logic [VAL_W-1:0]   largest;
  logic               any_token;
  logic               saturated_q;
  status_t            status_q;

  // Predicted results, oldest first
  result_t            reports_due[$];

  function automatic logic is_separator(input logic [CHAR_W-1:0] c);
    return c == CH_SPACE || c == CH_LF || c == CH_TAB;
  endfunction

  // Advance the parser by one character and return the report it produces
  function automatic result_t parse_char(input logic [CHAR_W-1:0] c);
    logic        tok_char;
    logic [5:0]  digit;
    logic [63:0] headroom;
    result_t     r;
    tok_char = 1'b1;
    digit    = '0;
    if (c >= CH_0 && c <= CH_9) begin
      digit = 6'(c - CH_0);
    end else if (c >= CH_A && c <= CH_Z) begin
      digit = 6'(c - CH_A + 8'd10);
    end else begin
      tok_char = 1'b0;
    end

    if (status_q != ST_RUN) begin
      // sticky status: hold everything
    end else if (stop_pos != STOP_IDLE) begin
      // inside the stop-word window
      if (is_separator(c)) begin
        status_q = ST_INPUT_ERR;
      end else begin
        if (c != ((stop_pos == STOP_WANT_O) ? CH_O : CH_P)) stop_miss = 1'b1;
        if (stop_pos == STOP_WANT_P) begin
          status_q = stop_miss ? ST_INPUT_ERR : ST_STOP;
          stop_pos = STOP_IDLE;
        end else begin
          stop_pos = STOP_WANT_P;
        end
      end
    end else if (sign_pending && !tok_char) begin
      status_q = ST_SIGN_ERR;
    end else begin
      sign_pending = 1'b0;
      if (is_separator(c)) begin
        // close the open token
        if (token_open) begin
          if (token_bad) begin
            status_q = ST_INPUT_ERR;
          end else begin
            if (token_value > largest) largest = token_value;
            any_token = 1'b1;
          end
          token_value = '0;
          token_bad   = 1'b0;
          token_open  = 1'b0;
          last_was_s  = 1'b0;
        end
      end else if (tok_char) begin
        // multiply-add with saturation at the top of the range
        if (digit >= radix_q) token_bad = 1'b1;
        if (radix_q == 0) begin
          token_value = VAL_W'(digit);
        end else begin
          headroom = ({1'b0, VAL_MAX} - 64'(digit)) / 64'(radix_q);
          if (64'(token_value) > headroom) begin
            token_value = VAL_MAX;
            saturated_q = 1'b1;
          end else begin
            token_value = VAL_W'(64'(token_value) * 64'(radix_q) + 64'(digit));
          end
        end
        token_open = 1'b1;
        last_was_s = (c == CH_S);
      end else if (c == CH_MINUS) begin
        sign_pending = 1'b1;
      end else if (last_was_s) begin
        stop_pos  = STOP_WANT_O;
        stop_miss = (c != CH_T);
      end else begin
        status_q = ST_INPUT_ERR;
      end
    end

    r.status      = status_q;
    r.max_value   = largest;
    r.have_number = any_token;
    r.saturated   = saturated_q;
    return r;
  endfunction

  // Watch all three channels; compare before queuing so a result can never
  // be matched against the character taken at the same edge
  always @(posedge clk) begin : watch
    int      errs;
    result_t got;
    result_t want;
    if (!rst_n) begin
      radix_q      = RADIX_RESET;
      token_value  = '0;
      token_open   = 1'b0;
      token_bad    = 1'b0;
      sign_pending = 1'b0;
      last_was_s   = 1'b0;
      stop_pos     = STOP_IDLE;
      stop_miss    = 1'b0;
      largest      = '0;
      any_token    = 1'b0;
      saturated_q  = 1'b0;
      status_q     = ST_RUN;
      reports_due.delete();
      mismatch_count      <= 0;
      reports_outstanding <= 0;
    end else begin
      errs = 0;
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[RESULT_W-1:0]);
        if (reports_due.size() == 0) begin
          $error("result transaction with no character outstanding: %h", out_tdata);
          errs++;
        end else begin
          want = reports_due.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errs++;
          end
          if (got.max_value !== want.max_value) begin
            $error("max_value: expected %0d, got %0d", want.max_value, got.max_value);
            errs++;
          end
          if (got.have_number !== want.have_number) begin
            $error("have_number: expected %0b, got %0b", want.have_number,
                   got.have_number);
            errs++;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) reports_due.push_back(parse_char(in_tdata));
      // a radix write takes effect after the character taken at the same edge
      if (cfg_valid && cfg_ready) radix_q = cfg_data;
      mismatch_count      <= mismatch_count + errs;
      reports_outstanding <= reports_due.size();
    end
  end

endmodule

>>> tb/radix_token_max_finder_test.sv
// Test top for radix_token_max_finder: clock, reset, character and radix
// stimulus, receiver stalls, watchdog and verdict.
// Depends on rtf_pkg, the DUT and radix_token_max_finder_checker.
module radix_token_max_finder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rtf_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [RADIX_W-1:0] cfg_data   = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [CHAR_W-1:0]  in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;

  int                 mismatch_count;
  int                 reports_outstanding;
  int                 quiet_cycles = 0;
  int                 src_gap_pct  = 38;
  int                 sink_gap_pct = 46;
  int                 chars_sent   = 0;
  logic [RADIX_W-1:0] cur_radix    = RADIX_RESET;

  always #4 clk = ~clk;

  radix_token_max_finder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  radix_token_max_finder_checker result_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .mismatch_count      (mismatch_count),
    .reports_outstanding (reports_outstanding)
  );

  // Receiver: stall at random
  always @(posedge clk) out_tready <= ($urandom_range(99) >= sink_gap_pct);

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("radix_token_max_finder test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one character, idling at random first, and wait for the transaction
  task automatic send_char(input logic [CHAR_W-1:0] c);
    while ($urandom_range(99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  // Drain all results, then write the radix
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (reports_outstanding != 0);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_radix = r;
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input int d);
    return (d < 10) ? CHAR_W'(CH_0 + d) : CHAR_W'(CH_A + d - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_separator();
    case ($urandom_range(2))
      0:       return CH_SPACE;
      1:       return CH_LF;
      default: return CH_TAB;
    endcase
  endfunction

  // Any byte that is not a digit, a separator or a minus
  function automatic logic [CHAR_W-1:0] random_other();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(255));
    while ((c >= CH_0 && c <= CH_9) || (c >= CH_A && c <= CH_Z) || c == CH_SPACE ||
           c == CH_LF || c == CH_TAB || c == CH_MINUS);
    return c;
  endfunction

  // One token, valid for a nonzero current radix, with stray signs, then separators;
  // a sign is always followed by a digit so the stream keeps running
  task automatic send_token(input int len);
    int span;
    span = (cur_radix == 0 || cur_radix > 36) ? 36 : int'(cur_radix);
    if ($urandom_range(9) == 0) send_char(CH_MINUS);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(19) == 0) send_char(CH_MINUS);
      send_char(digit_char($urandom_range(span - 1)));
    end
    send_char(pick_separator());
    if ($urandom_range(4) == 0) send_char(pick_separator());
  endtask

  // Well-formed tokens of mostly short length, a few long enough to saturate
  task automatic run_tokens(input int count);
    int start;
    int roll;
    start = chars_sent;
    while (chars_sent - start < count) begin
      roll = $urandom_range(99);
      if (roll < 4)       send_token($urandom_range(70, 12));
      else if (roll < 20) send_token($urandom_range(14, 9));
      else                send_token($urandom_range(8, 1));
    end
  endtask

  // Close the stream with one terminating case picked at random
  task automatic send_ending();
    int                kind;
    int                slot;
    logic [CHAR_W-1:0] word [3];
    logic [CHAR_W-1:0] odd;
    kind = $urandom_range(7);
    send_char(pick_separator());
    case (kind)
      0: send_text("Stop");
      1: begin
        // stop word with one wrong character
        word = '{CH_T, CH_O, CH_P};
        slot = $urandom_range(2);
        do odd = random_other(); while (odd == word[slot]);
        word[slot] = odd;
        send_char(CH_S);
        foreach (word[i]) send_char(word[i]);
      end
      2: begin
        // separator inside the stop window
        send_text("St");
        if ($urandom_range(1) == 0) send_char(CH_O);
        send_char(pick_separator());
      end
      3: begin
        send_char(CH_MINUS);
        send_char(($urandom_range(1) == 0) ? pick_separator() : random_other());
      end
      4: begin
        // digit at or above the radix, closed by a separator
        if (cur_radix < 36) begin
          send_char(digit_char($urandom_range(35, int'(cur_radix))));
          send_char(pick_separator());
        end else begin
          send_char(random_other());
        end
      end
      5: send_char(random_other());
      6: send_text("S-top");
      default: begin
        send_char(digit_char($urandom_range(9)));
        send_text("Stop");
      end
    endcase
  endtask

  initial begin
    logic [RADIX_W-1:0] plan [9];
    plan    = '{6'd2, 6'd36, 6'd63, 6'd1, 6'd16, 6'd37, 6'd0, 6'd0, RADIX_RESET};
    plan[6] = RADIX_W'($urandom_range(36, 2));
    plan[7] = RADIX_W'($urandom_range(63, 2));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Short directed run at the reset radix: zero, signs, tab, newline
    send_text("-0\t-9-9 \n7  3 ");

    for (int s = 0; s < 9; s++) begin
      if (s == 3) begin
        src_gap_pct  = 46;
        sink_gap_pct = 38;
      end
      if (s == 6) begin
        src_gap_pct  = 0;
        sink_gap_pct = 0;
      end
      write_radix(plan[s]);
      // largest value that fits without saturating
      if (plan[s] == 2) begin
        repeat (63) send_char(digit_char(1));
        send_char(CH_SPACE);
      end
      run_tokens(35);
    end

    // Terminate under an edge or random radix, then show the status sticks
    case ($urandom_range(2))
      0:       write_radix('0);
      1:       write_radix(6'd63);
      default: write_radix(RADIX_W'($urandom_range(63, 1)));
    endcase
    send_ending();
    send_char(8'h00);
    send_char(8'hFF);
    repeat (24) send_char(CHAR_W'($urandom_range(255)));
    in_tvalid <= 1'b0;

    do @(posedge clk); while (reports_outstanding != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("radix_token_max_finder test passed");
    end else begin
      $display("radix_token_max_finder test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rtf_pkg.sv
rtl/radix_token_max_finder.sv
tb/radix_token_max_finder_checker.sv
tb/radix_token_max_finder_test.sv
